FILE: design/b64_pkg.sv
// ----------------------------------------------------------------------------
// b64_pkg
// Shared types and character tables for the Base64 codec.
// ----------------------------------------------------------------------------
`default_nettype none

package b64_pkg;

  localparam int unsigned QueueDepth = 2;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       has_byte;
    logic       end_of_message;
  } b64_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_item;
    logic       message_done;
  } b64_out_t;

  // One classified item: up to four output bytes, first one in slot 0
  typedef struct packed {
    logic [0:3][7:0] data;
    logic [1:0]      last_idx;
    logic            eom;
  } b64_job_t;

  // Queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic valid;
  } b64_qstat_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } b64_sextet_t;

  localparam logic [7:0] CharPad = 8'h3D;  // '='

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

  function automatic b64_sextet_t b64_sextet(input logic [7:0] c);
    b64_sextet_t s;
    s.ok  = 1'b1;
    s.val = '0;
    if (c inside {[8'h41:8'h5A]}) begin
      s.val = 6'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      s.val = 6'(c - 8'h61 + 8'd26);
    end else if (c inside {[8'h30:8'h39]}) begin
      s.val = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      s.val = 6'd62;
    end else if (c == 8'h2F) begin
      s.val = 6'd63;
    end else begin
      s.ok = 1'b0;
    end
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: design/b64_front.sv
// ----------------------------------------------------------------------------
// b64_front
// Accepts items, keeps the partial group and forms the output bytes of each.
// ----------------------------------------------------------------------------
`default_nettype none

module b64_front import b64_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  input  wire logic       in_valid_i,
  input  wire b64_in_t    in_item_i,
  input  wire b64_qstat_t q_stat_i,
  output logic            push_o,
  output b64_job_t        job_o
);

  logic        mode_q;
  logic [23:0] bits_q, bits_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        accept;
  logic        has_job;
  logic [23:0] bits_n;
  logic [1:0]  cnt_n;
  logic [1:0]  c;
  logic        full;
  b64_sextet_t sx;
  logic [0:3][7:0] chars;

  assign accept = in_valid_i && !q_stat_i.full;
  assign sx     = b64_sextet(in_item_i.in_byte);

  always_comb begin
    bits_n  = bits_q;
    cnt_n   = cnt_q;
    full    = 1'b0;
    has_job = 1'b0;
    job_o   = '0;
    c       = '0;
    chars   = '0;
    job_o.eom = in_item_i.end_of_message;
    if (!mode_q) begin
      c = (cnt_q == 2'd3) ? 2'd2 : cnt_q;
      if (in_item_i.has_byte) begin
        case (c)
          2'd0:    bits_n = bits_q | {in_item_i.in_byte, 16'h0000};
          2'd1:    bits_n = bits_q | {8'h00, in_item_i.in_byte, 8'h00};
          default: bits_n = bits_q | {16'h0000, in_item_i.in_byte};
        endcase
        cnt_n = c + 2'd1;
        full  = (cnt_n == 2'd3);
      end
      for (int i = 0; i < 4; i++) begin
        chars[i] = b64_char(bits_n[23 - 6*i -: 6]);
      end
      if (full) begin
        has_job        = 1'b1;
        job_o.data     = chars;
        job_o.last_idx = 2'd3;
      end else if (in_item_i.end_of_message && cnt_n != 2'd0) begin
        // partial group: cnt+1 characters, then pad
        has_job        = 1'b1;
        job_o.last_idx = 2'd3;
        for (int i = 0; i < 4; i++) begin
          job_o.data[i] = (2'(i) <= cnt_n) ? chars[i] : CharPad;
        end
      end
    end else begin
      if (in_item_i.has_byte && sx.ok) begin
        case (cnt_q)
          2'd0:    bits_n = bits_q | {sx.val, 18'h0};
          2'd1:    bits_n = bits_q | {6'h0, sx.val, 12'h0};
          2'd2:    bits_n = bits_q | {12'h0, sx.val, 6'h0};
          default: bits_n = bits_q | {18'h0, sx.val};
        endcase
        if (cnt_q == 2'd3) begin
          full = 1'b1;
        end else begin
          cnt_n = cnt_q + 2'd1;
        end
      end
      job_o.data = {bits_n, 8'h00};
      if (full) begin
        has_job        = 1'b1;
        job_o.last_idx = 2'd2;
      end else if (in_item_i.end_of_message && cnt_n >= 2'd2) begin
        has_job        = 1'b1;
        job_o.last_idx = cnt_n - 2'd2;
      end
    end
  end

  always_comb begin
    bits_d = bits_n;
    cnt_d  = cnt_n;
    if (full || in_item_i.end_of_message) begin
      bits_d = '0;
      cnt_d  = '0;
    end
  end

  assign push_o = accept && has_job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      bits_q <= '0;
      cnt_q  <= '0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
      bits_q <= '0;
      cnt_q  <= '0;
    end else if (accept) begin
      bits_q <= bits_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/b64_queue.sv
// ----------------------------------------------------------------------------
// b64_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module b64_queue import b64_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire b64_job_t   job_i,
  input  wire logic       pop_i,
  output b64_qstat_t      stat_o,
  output b64_job_t        job_o
);

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  b64_job_t            mem_q [QueueDepth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [CntW-1:0]     cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == CntW'(QueueDepth));
  assign stat_o.valid = (cnt_q != '0);
  assign job_o        = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

FILE: design/b64_back.sv
// ----------------------------------------------------------------------------
// b64_back
// Sends the bytes of each queued item, one per cycle while the output is not stalled, as registered output.
// ----------------------------------------------------------------------------
`default_nettype none

module b64_back import b64_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire b64_qstat_t q_stat_i,
  input  wire b64_job_t   job_i,
  output logic            pop_o,
  input  wire logic       out_stall_i,
  output logic            out_valid_o,
  output b64_out_t        out_item_o
);

  logic       busy_q, busy_d;
  b64_job_t   job_q;
  logic [1:0] idx_q, idx_d;
  logic       take, is_last, finish;

  assign out_valid_o = busy_q;
  assign take        = busy_q && !out_stall_i;
  assign is_last     = (idx_q == job_q.last_idx);
  assign finish      = take && is_last;
  assign pop_o       = q_stat_i.valid && (!busy_q || finish);

  assign out_item_o.out_byte     = job_q.data[idx_q];
  assign out_item_o.last_of_item = is_last;
  assign out_item_o.message_done = is_last && job_q.eom;

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    if (pop_o) begin
      busy_d = 1'b1;
      idx_d  = '0;
    end else if (finish) begin
      busy_d = 1'b0;
    end else if (take) begin
      idx_d = idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
  end

endmodule

`default_nettype wire

FILE: design/base64_codec.sv
// ----------------------------------------------------------------------------
// base64_codec
// Streaming Base64 encoder/decoder, standard alphabet, mode set by register.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+-------------------------
//   in       | input     | in_valid_i / in_stall_o | in_item_i  (b64_in_t)
//   out      | output    | out_valid_o/ out_stall_i| out_item_o (b64_out_t)
//   cfg      | input     | cfg_we_i                | cfg_wdata_i (decode mode)
//
// An item yields 0 to 4 output bytes that leave at one per cycle while the
// output is not stalled, so throughput is set by the output port.
// The front waits only while the two-entry queue is full.
// An item passes through a queue entry, then the back stage register, before output.
// Reset clears mode (encode), the partial group, the queue and the back stage.
// A stalled output holds its byte; the front keeps taking items into the queue until it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_codec import b64_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cfg_we_i,
  input  wire logic     cfg_wdata_i,
  input  wire logic     in_valid_i,
  input  wire b64_in_t  in_item_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output b64_out_t      out_item_o
);

  // front -> queue
  logic       job_push;
  b64_job_t   job_in;
  // queue -> back
  b64_qstat_t q_stat;
  b64_job_t   job_out;
  logic       job_pop;

  // Front stalls only on a full queue, never on the output side directly
  assign in_stall_o = q_stat.full;

  b64_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .q_stat_i    (q_stat),
    .push_o      (job_push),
    .job_o       (job_in)
  );

  b64_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .job_i  (job_in),
    .pop_i  (job_pop),
    .stat_o (q_stat),
    .job_o  (job_out)
  );

  b64_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .job_i       (job_out),
    .pop_o       (job_pop),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

`ifndef ASSERT_OFF
  // No push into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_push |-> !q_stat.full)
    else $error("queue overflow");

  // Back pops only when an item is queued
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> q_stat.valid)
    else $error("queue underflow");

  // Queue fills only through a push
  a_full_by_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(q_stat.full) |-> $past(job_push))
    else $error("queue full without push");

  // An output taken while the queue holds work keeps the output busy
  a_back_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && q_stat.valid) |=> out_valid_o)
    else $error("back stage idled with queued work");
`endif

endmodule

`default_nettype wire
